// File: rtl/core/circular_queue_with_reverse_macros.svh
// ---------------------------------------------------------------------------
// circular_queue_with_reverse assertion macros
// Shared concurrent assertion shorthands for the queue checker.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_WITH_REVERSE_MACROS_SVH
`define CIRCULAR_QUEUE_WITH_REVERSE_MACROS_SVH

// checked only outside reset
`define CQR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CQR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/cqr_pkg.sv
// ---------------------------------------------------------------------------
// cqr_pkg
// Constants, codes and types shared by the circular queue modules.
// ---------------------------------------------------------------------------
package cqr_pkg;

	localparam int QUEUE_SLOTS  = 16;
	localparam int WORD_BITS    = 32;
	localparam int STACK_SLOTS  = QUEUE_SLOTS - 1;
	localparam int PTR_BITS     = $clog2(QUEUE_SLOTS);
	localparam int STK_IDX_BITS = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
	localparam int TOP_BITS     = $clog2(STACK_SLOTS + 1);

	localparam logic [1:0] OP_ADD      = 2'd0;
	localparam logic [1:0] OP_REMOVE   = 2'd1;
	localparam logic [1:0] OP_REVERSE  = 2'd2;
	localparam logic [1:0] OP_TRAVERSE = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef logic [PTR_BITS-1:0] ptr_t;

	typedef struct packed {
		logic [1:0]                  op;
		logic signed [WORD_BITS-1:0] value;
	} cmd_t;

	function automatic ptr_t next_slot(input ptr_t p);
		next_slot = (p == ptr_t'(QUEUE_SLOTS - 1)) ? '0 : ptr_t'(p + 1'b1);
	endfunction

endpackage

// File: rtl/core/circular_queue_with_reverse.sv
// ---------------------------------------------------------------------------
// circular_queue_with_reverse
// Circular FIFO of signed words with remove, reverse and traverse requests.
// ---------------------------------------------------------------------------
// Holds up to QUEUE_SLOTS-1 words (one slot stays empty). Each request on the
// slave side gives one or more results on the master side; tlast marks the
// final result of a request. The front end buffers two requests, so requests
// are taken while a result waits. The back end runs one request at a time
// around a queue memory with one registered read port: add and remove give
// one result, traverse of n words gives one read and one result per word,
// reverse makes n reads into the reversal stack and n reads back, plus
// turnaround. An empty queue answers any request with one result. Stalls on
// the master side hold the back end.
module circular_queue_with_reverse import cqr_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic signed [WORD_BITS-1:0] s_tdata,   // [31:0] item_value
	input  logic [1:0]                  s_tuser,   // [1:0] operation
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic signed [WORD_BITS-1:0] m_tdata,   // [31:0] out_value
	output logic [1:0]                  m_tuser,   // [1:0] status
	output logic                        m_tlast
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	cqr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	cqr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// File: rtl/core/cqr_front.sv
// ---------------------------------------------------------------------------
// cqr_front
// Accepts requests, decodes them into commands and buffers two of them.
// ---------------------------------------------------------------------------
module cqr_front import cqr_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic signed [WORD_BITS-1:0] s_tdata,   // item_value
	input  logic [1:0]                  s_tuser,   // operation
	output logic                        cmd_valid,
	output cmd_t                        cmd,
	input  logic                        cmd_pop
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       cmd_in;

	// only add carries a word; other requests drop it
	always_comb begin
		cmd_in.op    = s_tuser;
		cmd_in.value = (s_tuser == OP_ADD) ? s_tdata : '0;
	end

	assign s_tready  = (cnt_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/core/cqr_back.sv
// ---------------------------------------------------------------------------
// cqr_back
// Sequencer with queue and reversal stores; drives the result register.
// ---------------------------------------------------------------------------
module cqr_back import cqr_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  cmd_t                        cmd,
	output logic                        cmd_pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic signed [WORD_BITS-1:0] m_tdata,   // out_value
	output logic [1:0]                  m_tuser,   // status
	output logic                        m_tlast    // last_of_run
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EMIT  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_DWAIT = 3'd3;
	localparam logic [2:0] ST_FILL  = 3'd4;
	localparam logic [2:0] ST_TRAV  = 3'd5;

	logic [2:0]          state_q;
	ptr_t                front_q, rear_q, cur_q;
	logic [TOP_BITS-1:0] top_q;
	logic [1:0]          res_status_q;
	logic                res_use_rd_q, res_last_q, res_more_q;

	logic [WORD_BITS-1:0] queue_mem [QUEUE_SLOTS];
	logic [WORD_BITS-1:0] stack_mem [STACK_SLOTS];
	logic [WORD_BITS-1:0] q_rd_data_q, stk_rd_data_q;

	logic                    stk_wr_s1;
	logic [STK_IDX_BITS-1:0] stk_idx_s1;
	logic                    qwr_s1;
	ptr_t                    qwr_idx_s1;

	logic                    empty, full, slot_free;
	logic                    q_rd_en, q_wr_en, stk_rd_en;
	ptr_t                    q_rd_addr, q_wr_addr;
	logic [WORD_BITS-1:0]    q_wr_data;
	logic [STK_IDX_BITS-1:0] stk_rd_addr;
	logic                    m_tvalid_q;

	assign empty       = (front_q == rear_q);
	assign full        = (front_q == next_slot(rear_q));
	assign slot_free   = !m_tvalid_q || m_tready;
	assign cmd_pop     = (state_q == ST_IDLE) && cmd_valid;
	assign stk_rd_addr = STK_IDX_BITS'(top_q - TOP_BITS'(1));

	always_comb begin
		q_rd_en   = 1'b0;
		q_rd_addr = front_q;
		stk_rd_en = 1'b0;
		case (state_q)
			ST_IDLE:  q_rd_en = cmd_valid && (cmd.op == OP_REMOVE) && !empty;
			ST_DRAIN: q_rd_en = 1'b1;
			ST_TRAV: begin
				q_rd_en   = 1'b1;
				q_rd_addr = cur_q;
			end
			ST_FILL:  stk_rd_en = 1'b1;
			default:  q_rd_en = 1'b0;
		endcase
	end

	// refill writes never overlap an add: adds are taken only in idle
	assign q_wr_en   = qwr_s1 ||
		((state_q == ST_IDLE) && cmd_valid && (cmd.op == OP_ADD) && !full);
	assign q_wr_addr = qwr_s1 ? qwr_idx_s1 : rear_q;
	assign q_wr_data = qwr_s1 ? stk_rd_data_q : cmd.value;

	always_ff @(posedge clk) begin
		if (q_wr_en) begin
			queue_mem[q_wr_addr] <= q_wr_data;
		end
		if (q_rd_en) begin
			q_rd_data_q <= queue_mem[q_rd_addr];
		end
		if (stk_wr_s1) begin
			stack_mem[stk_idx_s1] <= q_rd_data_q;
		end
		if (stk_rd_en) begin
			stk_rd_data_q <= stack_mem[stk_rd_addr];
		end
		stk_idx_s1 <= STK_IDX_BITS'(top_q);
		qwr_idx_s1 <= rear_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			front_q      <= '0;
			rear_q       <= '0;
			cur_q        <= '0;
			top_q        <= '0;
			res_status_q <= STAT_OK;
			res_use_rd_q <= 1'b0;
			res_last_q   <= 1'b0;
			res_more_q   <= 1'b0;
			stk_wr_s1    <= 1'b0;
			qwr_s1       <= 1'b0;
		end else begin
			stk_wr_s1 <= (state_q == ST_DRAIN);
			qwr_s1    <= (state_q == ST_FILL);
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						res_status_q <= STAT_OK;
						res_use_rd_q <= 1'b0;
						res_last_q   <= 1'b1;
						res_more_q   <= 1'b0;
						state_q      <= ST_EMIT;
						case (cmd.op)
							OP_ADD: begin
								if (full) begin
									res_status_q <= STAT_FULL;
								end else begin
									rear_q <= next_slot(rear_q);
								end
							end
							OP_REMOVE: begin
								if (empty) begin
									res_status_q <= STAT_EMPTY;
								end else begin
									front_q      <= next_slot(front_q);
									res_use_rd_q <= 1'b1;
								end
							end
							OP_REVERSE: begin
								if (!empty) begin
									top_q   <= '0;
									state_q <= ST_DRAIN;
								end
							end
							OP_TRAVERSE: begin
								if (empty) begin
									res_status_q <= STAT_EMPTY;
								end else begin
									cur_q   <= front_q;
									state_q <= ST_TRAV;
								end
							end
							default: state_q <= ST_EMIT;
						endcase
					end
				end
				ST_DRAIN: begin
					front_q <= next_slot(front_q);
					top_q   <= top_q + TOP_BITS'(1);
					if (next_slot(front_q) == rear_q) begin
						state_q <= ST_DWAIT;
					end
				end
				// lets the last stack write land before the first pop
				ST_DWAIT: state_q <= ST_FILL;
				ST_FILL: begin
					top_q  <= top_q - TOP_BITS'(1);
					rear_q <= next_slot(rear_q);
					if (top_q == TOP_BITS'(1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_TRAV: begin
					cur_q        <= next_slot(cur_q);
					res_status_q <= STAT_OK;
					res_use_rd_q <= 1'b1;
					res_last_q   <= (next_slot(cur_q) == rear_q);
					res_more_q   <= (next_slot(cur_q) != rear_q);
					state_q      <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						state_q <= res_more_q ? ST_TRAV : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (slot_free) begin
			m_tvalid_q <= (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && (state_q == ST_EMIT)) begin
			m_tdata <= res_use_rd_q ? q_rd_data_q : '0;
			m_tuser <= res_status_q;
			m_tlast <= res_last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

// File: rtl/core/cqr_checker.sv
// ---------------------------------------------------------------------------
// cqr_checker
// Port-level checks on the circular queue, bound to the top level.
// ---------------------------------------------------------------------------
`include "circular_queue_with_reverse_macros.svh"

module cqr_checker import cqr_pkg::*; (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic signed [WORD_BITS-1:0] m_tdata,
	input logic [1:0]                  m_tuser,
	input logic                        m_tlast
);

	`CQR_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
	`CQR_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "data changed while stalled")
	`CQR_ASSERT(a_hold_ctl, m_tvalid && !m_tready |=> $stable(m_tuser) && $stable(m_tlast), "flags changed")
	`CQR_ASSERT(a_err_form, m_tvalid && m_tuser != STAT_OK |-> m_tdata == '0 && m_tlast, "bad error result")
	`CQR_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !m_tvalid, "result shown during reset")

endmodule

bind circular_queue_with_reverse cqr_checker u_cqr_checker (.*);
